// ===== rtl/core/slm_pkg.sv =====
// ----------------------------------------------------------------------------
// slm_pkg
// shared constants, register codes and field widths of the 3x3 valley detector
// ----------------------------------------------------------------------------
package slm_pkg;

  // fixed field widths
  localparam int unsigned PixelW    = 16;
  localparam int unsigned RowCountW = 11;
  localparam int unsigned ColCountW = 5;
  localparam int unsigned RowW      = 10;
  localparam int unsigned ColOutW   = 4;
  localparam int unsigned TotalW    = 16;
  localparam int unsigned ApbAddrW  = 3;
  localparam int unsigned ApbDataW  = 32;

  // frame limits
  localparam int unsigned MinSize  = 3;
  localparam int unsigned RowLimit = 1024;

  // register index, taken from paddr[2]
  typedef enum logic {
    RegRowCount    = 1'b0,
    RegColumnCount = 1'b1
  } reg_idx_e;

endpackage

// ===== rtl/core/slm_line_store.sv =====
// ----------------------------------------------------------------------------
// slm_line_store
// two line stores packed in one synchronous memory, registered read data,
// write-to-read forwarding and a clearing pass after reset
// ----------------------------------------------------------------------------
module slm_line_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned DW    = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  output logic [DW-1:0] rd_data_o,
  output logic          clearing_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rd_data_q;
  logic          clr_q, clr_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;
  logic          we;
  logic [AW-1:0] wa;
  logic [DW-1:0] wd;

  always_comb begin
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    if (clr_q) begin
      clr_cnt_d = clr_cnt_q + AW'(1);
      if (clr_cnt_q == AW'(DEPTH - 1)) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      clr_q     <= clr_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  assign we = clr_q | wr_en_i;
  assign wa = clr_q ? clr_cnt_q : wr_addr_i;
  assign wd = clr_q ? '0 : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
  end

  // a write landing in the same cycle as the read is forwarded
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o  = rd_data_q;
  assign clearing_o = clr_q;

endmodule

// ===== rtl/core/slm_window.sv =====
// ----------------------------------------------------------------------------
// slm_window
// 3x3 window shift register and strict minimum compare of its centre
// ----------------------------------------------------------------------------
module slm_window #(
  parameter int unsigned VW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  logic [VW-1:0] upper_i,
  input  logic [VW-1:0] middle_i,
  input  logic [VW-1:0] pix_i,
  output logic [VW-1:0] centre_o,
  output logic          valley_o
);

  logic [VW-1:0] win_q [9];
  logic [VW-1:0] win_d [9];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_d[k*3]     = win_q[k*3 + 1];
      win_d[k*3 + 1] = win_q[k*3 + 2];
    end
    win_d[2] = upper_i;
    win_d[5] = middle_i;
    win_d[8] = pix_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= '0;
      end
    end else if (shift_i) begin
      win_q <= win_d;
    end
  end

  always_comb begin
    valley_o = 1'b1;
    for (int k = 0; k < 9; k++) begin
      if (k != 4 && !(win_q[4] < win_q[k])) begin
        valley_o = 1'b0;
      end
    end
  end

  assign centre_o = win_q[4];

endmodule

// ===== rtl/core/strict_local_minimum_3x3_detector.sv =====
// ----------------------------------------------------------------------------
// strict_local_minimum_3x3_detector
// raster-order 3x3 strict local minimum finder with running valley count
// ----------------------------------------------------------------------------
// pipeline: request to result through line store read, window and result
// throughput: one request per cycle when not stalled, set by the line store's
//   read port in the accept cycle and its write port for the write-back
// reset: positions, counter and window clear at once; the line store is then
//   swept to zero entry by entry while in_stall_o is held high
module strict_local_minimum_3x3_detector #(
  parameter int unsigned MAX_COLUMNS = 16,
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // apb configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [slm_pkg::ApbAddrW-1:0]  paddr,
  input  logic [slm_pkg::ApbDataW-1:0]  pwdata,
  output logic [slm_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [slm_pkg::PixelW-1:0]    pixel_value_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          window_ready_o,
  output logic                          is_valley_o,
  output logic [slm_pkg::RowW-1:0]      centre_row_o,
  output logic [slm_pkg::ColOutW-1:0]   centre_column_o,
  output logic [slm_pkg::PixelW-1:0]    centre_value_o,
  output logic [slm_pkg::TotalW-1:0]    valley_total_o,
  output logic                          frame_done_o
);

  localparam int unsigned AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned EW = (AW + 1 > slm_pkg::ColCountW) ? AW + 1 : slm_pkg::ColCountW;
  localparam int unsigned VW = VALUE_WIDTH;
  localparam int unsigned RCW = slm_pkg::RowCountW;

  // ---------------- configuration ----------------
  logic [RCW-1:0]                 row_count_q;
  logic [slm_pkg::ColCountW-1:0]  col_count_q;
  logic                           cfg_wr;
  slm_pkg::reg_idx_e              cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = slm_pkg::reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= RCW'(slm_pkg::MinSize);
      col_count_q <= slm_pkg::ColCountW'(slm_pkg::MinSize);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        slm_pkg::RegRowCount:    row_count_q <= pwdata[RCW-1:0];
        slm_pkg::RegColumnCount: col_count_q <= pwdata[slm_pkg::ColCountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      slm_pkg::RegRowCount:    prdata = slm_pkg::ApbDataW'(row_count_q);
      slm_pkg::RegColumnCount: prdata = slm_pkg::ApbDataW'(col_count_q);
      default:                 prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic s1_v_q, s2_v_q, out_v_q;
  logic out_load, s2_load, s1_load, acc, s1_move, s2_move;
  logic clearing;

  assign out_load = !out_v_q || !out_stall_i;
  assign s2_load  = !s2_v_q || out_load;
  assign s1_load  = !s1_v_q || s2_load;
  assign in_stall_o = clearing || !s1_load;
  assign acc      = in_valid_i && !in_stall_o;
  assign s1_move  = s1_v_q && s2_load;
  assign s2_move  = s2_v_q && out_load;

  // ---------------- position tracking at accept ----------------
  logic [AW-1:0]           c_pos_q, c_pos_d;
  logic [slm_pkg::RowW-1:0] r_pos_q, r_pos_d;
  logic [EW-1:0]           cols, c_ext, c_eff_ext;
  logic [RCW-1:0]          rows, r_ext, r_eff_ext;
  logic [AW-1:0]           c_eff;
  logic                    last_col, done, ready;
  logic [VW-1:0]           pix;

  always_comb begin
    cols = EW'(col_count_q);
    if (cols < EW'(slm_pkg::MinSize)) begin
      cols = EW'(slm_pkg::MinSize);
    end else if (cols > EW'(MAX_COLUMNS)) begin
      cols = EW'(MAX_COLUMNS);
    end
    rows = row_count_q;
    if (rows < RCW'(slm_pkg::MinSize)) begin
      rows = RCW'(slm_pkg::MinSize);
    end else if (rows > RCW'(slm_pkg::RowLimit)) begin
      rows = RCW'(slm_pkg::RowLimit);
    end
    // a position past a shrunken frame counts as the last one
    c_ext     = EW'(c_pos_q);
    c_eff_ext = (c_ext >= cols) ? cols - EW'(1) : c_ext;
    c_eff     = c_eff_ext[AW-1:0];
    r_ext     = RCW'(r_pos_q);
    r_eff_ext = (r_ext >= rows) ? rows - RCW'(1) : r_ext;
    last_col  = (c_eff_ext + EW'(1)) >= cols;
    done      = last_col && ((r_eff_ext + RCW'(1)) >= rows);
    ready     = (r_eff_ext >= RCW'(2)) && (c_eff_ext >= EW'(2));
    if (done) begin
      c_pos_d = '0;
      r_pos_d = '0;
    end else if (last_col) begin
      c_pos_d = '0;
      r_pos_d = r_eff_ext[slm_pkg::RowW-1:0] + slm_pkg::RowW'(1);
    end else begin
      c_pos_d = c_eff + AW'(1);
      r_pos_d = r_eff_ext[slm_pkg::RowW-1:0];
    end
  end

  assign pix = VW'(pixel_value_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_pos_q <= '0;
      r_pos_q <= '0;
    end else if (acc) begin
      c_pos_q <= c_pos_d;
      r_pos_q <= r_pos_d;
    end
  end

  // ---------------- stage 1: line store read ----------------
  logic [VW-1:0]            s1_pix_q;
  logic [AW-1:0]            s1_c_q;
  logic [slm_pkg::RowW-1:0] s1_r_q;
  logic                     s1_ready_q, s1_done_q;
  logic [2*VW-1:0]          rd_data;
  logic [2*VW-1:0]          wr_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_load) begin
      s1_v_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_pix_q   <= pix;
      s1_c_q     <= c_eff;
      s1_r_q     <= r_eff_ext[slm_pkg::RowW-1:0];
      s1_ready_q <= ready;
      s1_done_q  <= done;
    end
  end

  // entry holds {upper, middle}; the middle row moves up, the pixel goes in
  assign wr_data = {rd_data[VW-1:0], s1_pix_q};

  slm_line_store #(
    .DEPTH (MAX_COLUMNS),
    .AW    (AW),
    .DW    (2*VW)
  ) u_line_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (acc),
    .rd_addr_i  (c_eff),
    .wr_en_i    (s1_move),
    .wr_addr_i  (s1_c_q),
    .wr_data_i  (wr_data),
    .rd_data_o  (rd_data),
    .clearing_o (clearing)
  );

  // ---------------- stage 2: window ----------------
  logic [AW-1:0]            s2_c_q;
  logic [slm_pkg::RowW-1:0] s2_r_q;
  logic                     s2_ready_q, s2_done_q;
  logic [VW-1:0]            centre;
  logic                     win_valley;

  slm_window #(
    .VW (VW)
  ) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .shift_i  (s1_move),
    .upper_i  (rd_data[2*VW-1:VW]),
    .middle_i (rd_data[VW-1:0]),
    .pix_i    (s1_pix_q),
    .centre_o (centre),
    .valley_o (win_valley)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_load) begin
      s2_v_q <= s1_move;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      s2_c_q     <= s1_c_q;
      s2_r_q     <= s1_r_q;
      s2_ready_q <= s1_ready_q;
      s2_done_q  <= s1_done_q;
    end
  end

  // ---------------- stage 3: result register ----------------
  logic [slm_pkg::TotalW-1:0]  cnt_q, cnt_d, total;
  logic                        valley;
  logic [AW-1:0]               c_dec;
  logic                        ready_q, valley_q, done_q;
  logic [slm_pkg::RowW-1:0]    row_q;
  logic [slm_pkg::ColOutW-1:0] col_q;
  logic [slm_pkg::PixelW-1:0]  val_q;
  logic [slm_pkg::TotalW-1:0]  total_q;

  always_comb begin
    valley = s2_ready_q && win_valley;
    total  = cnt_q;
    if (valley && (cnt_q != '1)) begin
      total = cnt_q + slm_pkg::TotalW'(1);
    end
    cnt_d = s2_done_q ? '0 : total;
    c_dec = s2_c_q - AW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      if (out_load) begin
        out_v_q <= s2_move;
      end
      if (s2_move) begin
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_move) begin
      ready_q  <= s2_ready_q;
      valley_q <= valley;
      row_q    <= s2_ready_q ? s2_r_q - slm_pkg::RowW'(1) : '0;
      col_q    <= s2_ready_q ? slm_pkg::ColOutW'(c_dec) : '0;
      val_q    <= s2_ready_q ? slm_pkg::PixelW'(centre) : '0;
      total_q  <= total;
      done_q   <= s2_done_q;
    end
  end

  assign out_valid_o     = out_v_q;
  assign window_ready_o  = ready_q;
  assign is_valley_o     = valley_q;
  assign centre_row_o    = row_q;
  assign centre_column_o = col_q;
  assign centre_value_o  = val_q;
  assign valley_total_o  = total_q;
  assign frame_done_o    = done_q;

  // ---------------- assertions ----------------
  // no request is taken while the line store is being swept
  assert property (@(posedge clk_i) disable iff (!rst_ni) clearing |-> !acc)
    else $error("request accepted during line store clear");

  // a result without a complete window carries no valley and no centre
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !window_ready_o) |-> (!is_valley_o && centre_value_o == '0))
    else $error("valley reported without a complete window");

  // a new valley mid-frame raises the count by exactly one until saturation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_move && valley && !s2_done_q && cnt_q != '1)
      |=> (cnt_q == $past(cnt_q) + slm_pkg::TotalW'(1)))
    else $error("valley counter did not step by one");

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the 3x3 strict valley detector
// ----------------------------------------------------------------------------
// A predictor follows every accepted pixel and queues the result it expects.
// Each result leaving the block is compared with the oldest queued one.
// Stimulus covers:
//   - reset defaults
//   - out-of-range sizes
//   - sizes changed in the middle of a frame
//   - one tall frame
//   - random frames
// Sender gaps and receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LineDepth  = 16;
  localparam int unsigned Latency    = 3;
  localparam int unsigned CycleLimit = 400_000;

  typedef struct packed {
    logic                        window_ready;
    logic                        is_valley;
    logic [slm_pkg::RowW-1:0]    centre_row;
    logic [slm_pkg::ColOutW-1:0] centre_column;
    logic [slm_pkg::PixelW-1:0]  centre_value;
    logic [slm_pkg::TotalW-1:0]  valley_total;
    logic                        frame_done;
  } window_result_t;

  typedef enum int unsigned {
    FillRandom,
    FillNarrow,
    FillValleyGrid,
    FillExtremes
  } fill_e;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         psel          = 1'b0;
  logic                         penable       = 1'b0;
  logic                         pwrite        = 1'b0;
  logic [slm_pkg::ApbAddrW-1:0] paddr         = '0;
  logic [slm_pkg::ApbDataW-1:0] pwdata        = '0;
  logic [slm_pkg::ApbDataW-1:0] prdata;
  logic                         pready;
  logic                         in_valid_i    = 1'b0;
  logic                         in_stall_o;
  logic [slm_pkg::PixelW-1:0]   pixel_value_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i   = 1'b0;
  logic                         window_ready_o;
  logic                         is_valley_o;
  logic [slm_pkg::RowW-1:0]     centre_row_o;
  logic [slm_pkg::ColOutW-1:0]  centre_column_o;
  logic [slm_pkg::PixelW-1:0]   centre_value_o;
  logic [slm_pkg::TotalW-1:0]   valley_total_o;
  logic                         frame_done_o;

  strict_local_minimum_3x3_detector u_top (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .in_valid_i,
    .in_stall_o,
    .pixel_value_i,
    .out_valid_o,
    .out_stall_i,
    .window_ready_o,
    .is_valley_o,
    .centre_row_o,
    .centre_column_o,
    .centre_value_o,
    .valley_total_o,
    .frame_done_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // predictor state
  logic [slm_pkg::RowCountW-1:0] row_count_cfg = slm_pkg::RowCountW'(slm_pkg::MinSize);
  logic [slm_pkg::ColCountW-1:0] col_count_cfg = slm_pkg::ColCountW'(slm_pkg::MinSize);
  logic [slm_pkg::PixelW-1:0]    upper_line    [LineDepth] = '{default: '0};
  logic [slm_pkg::PixelW-1:0]    middle_line   [LineDepth] = '{default: '0};
  logic [slm_pkg::PixelW-1:0]    neighbourhood [9]         = '{default: '0};
  int unsigned                   row_pos       = 0;
  int unsigned                   col_pos       = 0;
  int unsigned                   valley_count  = 0;
  bit                            frame_ended   = 1'b0;

  window_result_t expected_results [$];

  int unsigned gap_pct         = 0;
  int unsigned stall_pct       = 0;
  int unsigned cycle_count     = 0;
  int unsigned error_count     = 0;
  int unsigned pixels_sent     = 0;
  int unsigned results_checked = 0;
  int unsigned valleys_seen    = 0;
  int unsigned frames_seen     = 0;

  // works out the result of one pixel and advances the raster position
  function automatic window_result_t predict_window(
      input logic [slm_pkg::PixelW-1:0] pix);
    int unsigned    rows;
    int unsigned    cols;
    int unsigned    r;
    int unsigned    c;
    bit             last_col;
    window_result_t res;
    rows = (row_count_cfg < slm_pkg::MinSize) ? slm_pkg::MinSize :
           (row_count_cfg > slm_pkg::RowLimit) ? slm_pkg::RowLimit : row_count_cfg;
    cols = (col_count_cfg < slm_pkg::MinSize) ? slm_pkg::MinSize :
           (col_count_cfg > LineDepth) ? LineDepth : col_count_cfg;
    r = (row_pos >= rows) ? rows - 1 : row_pos;
    c = (col_pos >= cols) ? cols - 1 : col_pos;
    for (int k = 0; k < 3; k++) begin
      neighbourhood[k * 3]     = neighbourhood[k * 3 + 1];
      neighbourhood[k * 3 + 1] = neighbourhood[k * 3 + 2];
    end
    neighbourhood[2] = upper_line[c];
    neighbourhood[5] = middle_line[c];
    neighbourhood[8] = pix;
    upper_line[c]    = middle_line[c];
    middle_line[c]   = pix;
    res = '0;
    res.window_ready = (r >= 2) && (c >= 2);
    if (res.window_ready) begin
      res.is_valley = 1'b1;
      for (int k = 0; k < 9; k++) begin
        if (k != 4 && !(neighbourhood[4] < neighbourhood[k])) res.is_valley = 1'b0;
      end
      if (res.is_valley && valley_count < 32'hFFFF) valley_count++;
      res.centre_row    = slm_pkg::RowW'(r - 1);
      res.centre_column = slm_pkg::ColOutW'(c - 1);
      res.centre_value  = neighbourhood[4];
    end
    res.valley_total = slm_pkg::TotalW'(valley_count);
    last_col         = (c + 1 >= cols);
    res.frame_done   = last_col && (r + 1 >= rows);
    if (res.frame_done) begin
      row_pos      = 0;
      col_pos      = 0;
      valley_count = 0;
    end else if (last_col) begin
      col_pos = 0;
      row_pos = r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
    frame_ended = res.frame_done;
    return res;
  endfunction

  function automatic logic [slm_pkg::PixelW-1:0] pick_pixel(input fill_e fill);
    logic [slm_pkg::PixelW-1:0] value;
    case (fill)
      FillNarrow:   value = slm_pkg::PixelW'($urandom_range(3));
      FillExtremes: value = $urandom_range(1) ? '1 : '0;
      FillValleyGrid: begin
        // odd/odd cells low, the rest high, with a little noise
        if ($urandom_range(9) == 0) value = slm_pkg::PixelW'($urandom());
        else if (row_pos[0] && col_pos[0]) value = slm_pkg::PixelW'($urandom_range(16'h7FFF));
        else value = slm_pkg::PixelW'($urandom_range(16'hFFFF, 16'h8000));
      end
      default:      value = slm_pkg::PixelW'($urandom());
    endcase
    return value;
  endfunction

  function automatic fill_e random_fill();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll < 4) return FillValleyGrid;
    if (roll < 7) return FillRandom;
    if (roll < 9) return FillNarrow;
    return FillExtremes;
  endfunction

  task automatic send_pixel(input logic [slm_pkg::PixelW-1:0] value);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < gap_pct);
    end
    in_valid_i    <= 1'b1;
    pixel_value_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    expected_results.push_back(predict_window(value));
    pixels_sent++;
  endtask

  task automatic send_pixels(input int unsigned count, input fill_e fill);
    repeat (count) send_pixel(pick_pixel(fill));
  endtask

  task automatic run_to_frame_end(input fill_e fill);
    do send_pixel(pick_pixel(fill)); while (!frame_ended);
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
  endtask

  task automatic apb_transfer(input bit is_write, input slm_pkg::reg_idx_e idx,
                              input logic [slm_pkg::ApbDataW-1:0] data,
                              output logic [slm_pkg::ApbDataW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= slm_pkg::ApbAddrW'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
  endtask

  // only called with the block idle; reads the register back afterwards
  task automatic write_reg(input slm_pkg::reg_idx_e idx,
                           input logic [slm_pkg::ApbDataW-1:0] value);
    logic [slm_pkg::ApbDataW-1:0] readback;
    apb_transfer(1'b1, idx, value, readback);
    apb_transfer(1'b0, idx, '0, readback);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    if (idx == slm_pkg::RegRowCount) row_count_cfg = value[slm_pkg::RowCountW-1:0];
    else col_count_cfg = value[slm_pkg::ColCountW-1:0];
    if (readback !== value) begin
      $display("%0t: register %s readback expected %0d got %0d",
               $time, idx.name(), value, readback);
      error_count++;
    end
  endtask

  task automatic set_frame_size(input int unsigned rows, input int unsigned cols);
    write_reg(slm_pkg::RegRowCount, slm_pkg::ApbDataW'(rows));
    write_reg(slm_pkg::RegColumnCount, slm_pkg::ApbDataW'(cols));
  endtask

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d got %0d", $time, field, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    window_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected, expected none got centre %0d",
                 $time, centre_value_o);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        compare_field("window_ready", want.window_ready, window_ready_o);
        compare_field("is_valley", want.is_valley, is_valley_o);
        compare_field("centre_row", want.centre_row, centre_row_o);
        compare_field("centre_column", want.centre_column, centre_column_o);
        compare_field("centre_value", want.centre_value, centre_value_o);
        compare_field("valley_total", want.valley_total, valley_total_o);
        compare_field("frame_done", want.frame_done, frame_done_o);
        results_checked++;
        if (is_valley_o === 1'b1) valleys_seen++;
        if (frame_done_o === 1'b1) frames_seen++;
      end
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count == CycleLimit);
    $display("%0t: timeout after %0d cycles", $time, CycleLimit);
    $display("strict_local_minimum_3x3_detector verification failed");
    $finish;
  end

  // reset sizes: one clear valley, then a tie that must not count
  task automatic test_reset_defaults();
    logic [slm_pkg::PixelW-1:0] tie_frame [9];
    tie_frame = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF,
                  16'h7FFF, 16'h8000, 16'h8000, 16'h8000};
    gap_pct   = 0;
    stall_pct = 0;
    for (int k = 0; k < 9; k++) send_pixel((k == 4) ? 16'h0000 : 16'hFFFF);
    for (int k = 0; k < 9; k++) send_pixel(tie_frame[k]);
    wait_for_results();
  endtask

  // sizes outside the legal range are clamped by the block
  task automatic test_config_clamping();
    gap_pct   = 35;
    stall_pct = 35;
    set_frame_size(0, 31);
    run_to_frame_end(FillValleyGrid);
    wait_for_results();
    set_frame_size(2, 0);
    run_to_frame_end(FillExtremes);
    wait_for_results();
    set_frame_size(1, 17);
    run_to_frame_end(FillRandom);
    wait_for_results();
  endtask

  // shrink the frame while part way through it
  task automatic test_mid_frame_resize();
    gap_pct   = 35;
    stall_pct = 35;
    set_frame_size(slm_pkg::RowLimit, LineDepth);
    send_pixels(40, FillValleyGrid);
    // sender holds off until every request has come back
    wait_for_results();
    write_reg(slm_pkg::RegColumnCount, 4);
    send_pixels(8, FillRandom);
    wait_for_results();
    write_reg(slm_pkg::RegRowCount, slm_pkg::MinSize);
    run_to_frame_end(FillRandom);
    wait_for_results();
  endtask

  // tall frame at the narrowest width
  task automatic test_tall_frame();
    gap_pct   = 0;
    stall_pct = 0;
    set_frame_size(250, slm_pkg::MinSize);
    run_to_frame_end(FillValleyGrid);
    wait_for_results();
  endtask

  task automatic test_random_frames();
    int unsigned phase_gap   [4];
    int unsigned phase_stall [4];
    int unsigned phase_start;
    int unsigned rows;
    int unsigned cols;
    phase_gap   = '{0, 63, 0, 35};
    phase_stall = '{0, 0, 63, 35};
    for (int p = 0; p < 4; p++) begin
      gap_pct     = phase_gap[p];
      stall_pct   = phase_stall[p];
      phase_start = pixels_sent;
      while (pixels_sent - phase_start < 140) begin
        rows = $urandom_range(12, slm_pkg::MinSize);
        cols = $urandom_range(LineDepth, slm_pkg::MinSize);
        if ($urandom_range(9) == 0) rows = $urandom_range(slm_pkg::MinSize - 1);
        if ($urandom_range(9) == 0) begin
          cols = $urandom_range(1) ? $urandom_range(slm_pkg::MinSize - 1)
                                   : $urandom_range(31, 17);
        end
        set_frame_size(rows, cols);
        if ($urandom_range(7) == 0) begin
          // cut the frame short by resizing it part way
          send_pixels($urandom_range(30, 1), random_fill());
          wait_for_results();
          set_frame_size($urandom_range(5, slm_pkg::MinSize),
                         $urandom_range(LineDepth, slm_pkg::MinSize));
        end
        run_to_frame_end(random_fill());
        wait_for_results();
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_config_clamping();
    test_mid_frame_resize();
    test_tall_frame();
    test_random_frames();
    wait_for_results();
    $display("ran %0d pixels over %0d frames, %0d results checked, %0d valleys found",
             pixels_sent, frames_seen, results_checked, valleys_seen);
    $display("sizes clamped at both ends and cut short mid-frame, one tall narrow frame,");
    $display("with sender gaps and receiver stalls mixed phase by phase");
    if (error_count == 0) begin
      $display("strict_local_minimum_3x3_detector verification clean");
    end else begin
      $display("strict_local_minimum_3x3_detector verification failed");
    end
    $finish;
  end

endmodule
